// ----- design/ethf_pkg.sv -----
package ethf_pkg;

  localparam int MaxFrameBytesDef = 16383;

  localparam int ByteW    = 8;
  localparam int MacW     = 48;
  localparam int IpW      = 32;
  localparam int PortW    = 16;
  localparam int PayloadW = 14;
  localparam int VerdictW = 3;
  localparam int OutDataW = 112;

  localparam int HeaderBytes = 42;

  localparam logic [15:0]     EthertypeIpv4 = 16'h0800;
  localparam logic [7:0]      ProtoUdp      = 8'd17;
  localparam logic [MacW-1:0] BroadcastMac  = {MacW{1'b1}};

  typedef enum logic [VerdictW-1:0] {
    VerdictAccept   = 3'd0,
    VerdictBadMac   = 3'd1,
    VerdictNotIpv4  = 3'd2,
    VerdictNotUdp   = 3'd3,
    VerdictTooShort = 3'd4
  } verdict_e;

  typedef struct packed {
    verdict_e            verdict;
    logic [IpW-1:0]      source_ip;
    logic [IpW-1:0]      dest_ip;
    logic [PortW-1:0]    source_port;
    logic [PortW-1:0]    dest_port;
    logic [PayloadW-1:0] data_len;
  } result_t;

endpackage

// ----- design/ethf_parse.sv -----
module ethf_parse import ethf_pkg::*; #(
  parameter int MaxFrameBytes = MaxFrameBytesDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  logic [ByteW-1:0] byte_i,
  input  logic             last_i,
  input  logic [MacW-1:0]  own_mac_i,
  output result_t          result_o
);

  localparam int PosW = $clog2(MaxFrameBytes + 1);
  localparam int SumW = (PosW > PayloadW) ? PosW : PayloadW;

  logic [PosW-1:0]  pos_q, pos_d, len;
  logic [MacW-1:0]  dest_mac_q, dest_mac_d, dest_mac_c;
  logic [15:0]      ethertype_q, ethertype_d, ethertype_c;
  logic [7:0]       proto_q, proto_d, proto_c;
  logic [IpW-1:0]   src_ip_q, src_ip_d, src_ip_c;
  logic [IpW-1:0]   dst_ip_q, dst_ip_d, dst_ip_c;
  logic [PortW-1:0] src_port_q, src_port_d, src_port_c;
  logic [PortW-1:0] dst_port_q, dst_port_d, dst_port_c;
  logic [SumW-1:0]  payload_full;

  always_comb begin
    dest_mac_c  = dest_mac_q;
    ethertype_c = ethertype_q;
    proto_c     = proto_q;
    src_ip_c    = src_ip_q;
    dst_ip_c    = dst_ip_q;
    src_port_c  = src_port_q;
    dst_port_c  = dst_port_q;
    if (pos_q < PosW'(6)) begin
      dest_mac_c = {dest_mac_q[MacW-ByteW-1:0], byte_i};
    end else if (pos_q == PosW'(12) || pos_q == PosW'(13)) begin
      ethertype_c = {ethertype_q[7:0], byte_i};
    end else if (pos_q == PosW'(23)) begin
      proto_c = byte_i;
    end else if (pos_q >= PosW'(26) && pos_q < PosW'(30)) begin
      src_ip_c = {src_ip_q[IpW-ByteW-1:0], byte_i};
    end else if (pos_q >= PosW'(30) && pos_q < PosW'(34)) begin
      dst_ip_c = {dst_ip_q[IpW-ByteW-1:0], byte_i};
    end else if (pos_q == PosW'(34) || pos_q == PosW'(35)) begin
      src_port_c = {src_port_q[7:0], byte_i};
    end else if (pos_q == PosW'(36) || pos_q == PosW'(37)) begin
      dst_port_c = {dst_port_q[7:0], byte_i};
    end

    // saturate the byte count
    len = (pos_q < PosW'(MaxFrameBytes)) ? pos_q + PosW'(1) : PosW'(MaxFrameBytes);

    pos_d       = pos_q;
    dest_mac_d  = dest_mac_q;
    ethertype_d = ethertype_q;
    proto_d     = proto_q;
    src_ip_d    = src_ip_q;
    dst_ip_d    = dst_ip_q;
    src_port_d  = src_port_q;
    dst_port_d  = dst_port_q;
    if (step_i) begin
      if (last_i) begin
        pos_d       = '0;
        dest_mac_d  = '0;
        ethertype_d = '0;
        proto_d     = '0;
        src_ip_d    = '0;
        dst_ip_d    = '0;
        src_port_d  = '0;
        dst_port_d  = '0;
      end else begin
        pos_d       = len;
        dest_mac_d  = dest_mac_c;
        ethertype_d = ethertype_c;
        proto_d     = proto_c;
        src_ip_d    = src_ip_c;
        dst_ip_d    = dst_ip_c;
        src_port_d  = src_port_c;
        dst_port_d  = dst_port_c;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      dest_mac_q  <= '0;
      ethertype_q <= '0;
      proto_q     <= '0;
      src_ip_q    <= '0;
      dst_ip_q    <= '0;
      src_port_q  <= '0;
      dst_port_q  <= '0;
    end else begin
      pos_q       <= pos_d;
      dest_mac_q  <= dest_mac_d;
      ethertype_q <= ethertype_d;
      proto_q     <= proto_d;
      src_ip_q    <= src_ip_d;
      dst_ip_q    <= dst_ip_d;
      src_port_q  <= src_port_d;
      dst_port_q  <= dst_port_d;
    end
  end

  assign payload_full = SumW'(len) - SumW'(HeaderBytes);

  always_comb begin
    result_o.source_ip   = src_ip_c;
    result_o.dest_ip     = dst_ip_c;
    result_o.source_port = src_port_c;
    result_o.dest_port   = dst_port_c;
    result_o.data_len    = '0;
    if (len < PosW'(HeaderBytes)) begin
      result_o.verdict = VerdictTooShort;
    end else if (dest_mac_c != own_mac_i && dest_mac_c != BroadcastMac) begin
      result_o.verdict = VerdictBadMac;
    end else if (ethertype_c != EthertypeIpv4) begin
      result_o.verdict = VerdictNotIpv4;
    end else if (proto_c != ProtoUdp) begin
      result_o.verdict = VerdictNotUdp;
    end else begin
      result_o.verdict  = VerdictAccept;
      result_o.data_len = payload_full[PayloadW-1:0];
    end
  end

endmodule

// ----- design/ethf_out_reg.sv -----
module ethf_out_reg import ethf_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    load_i,
  input  result_t result_i,
  input  logic    ready_i,
  output logic    valid_o,
  output logic    space_o,
  output result_t result_o
);

  logic    valid_q, valid_d;
  result_t result_q;

  assign space_o = !valid_q || ready_i;
  assign valid_d = load_i ? 1'b1 : (ready_i ? 1'b0 : valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      result_q <= result_i;
    end
  end

  assign valid_o  = valid_q;
  assign result_o = result_q;

endmodule

// ----- design/eth_ipv4_udp_header_filter_core.sv -----
// The tlast byte passes the input register, then its result loads the output register.
// Throughput: one byte per cycle unless stalled; bytes flow while a result waits on m_axis.
// A final byte stalls in the input register only while the output register is full and held.
// Reset (rst_ni low, asynchronous): own MAC cleared, frame position and captures cleared,
// input and output registers empty.
module eth_ipv4_udp_header_filter_core import ethf_pkg::*; #(
  parameter int MaxFrameBytes = MaxFrameBytesDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [MacW-1:0]     cfg_wdata_i,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [ByteW-1:0]    s_axis_tdata,   // byte_value
  input  logic                s_axis_tlast,   // frame_end
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // source_ip[31:0], dest_ip[63:32], source_port[79:64], dest_port[95:80],
  // data_len[109:96], zero[111:110]
  output logic [OutDataW-1:0] m_axis_tdata,
  output logic [VerdictW-1:0] m_axis_tuser    // verdict
);

  logic [MacW-1:0]  own_mac_q;
  logic             in_valid_q, in_valid_d;
  logic [ByteW-1:0] in_byte_q;
  logic             in_last_q;
  logic             s_fire, advance, out_space, out_load;
  result_t          parse_result, out_result;

  assign advance       = in_valid_q && (!in_last_q || out_space);
  assign s_axis_tready = !in_valid_q || advance;
  assign s_fire        = s_axis_tvalid && s_axis_tready;
  assign out_load      = advance && in_last_q;
  assign in_valid_d    = s_fire ? 1'b1 : (advance ? 1'b0 : in_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_mac_q  <= '0;
      in_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        own_mac_q <= cfg_wdata_i;
      end
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      in_byte_q <= s_axis_tdata;
      in_last_q <= s_axis_tlast;
    end
  end

  ethf_parse #(
    .MaxFrameBytes(MaxFrameBytes)
  ) u_parse (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (advance),
    .byte_i    (in_byte_q),
    .last_i    (in_last_q),
    .own_mac_i (own_mac_q),
    .result_o  (parse_result)
  );

  ethf_out_reg u_out_reg (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (out_load),
    .result_i (parse_result),
    .ready_i  (m_axis_tready),
    .valid_o  (m_axis_tvalid),
    .space_o  (out_space),
    .result_o (out_result)
  );

  assign m_axis_tuser = out_result.verdict;
  assign m_axis_tdata = {2'b00, out_result.data_len, out_result.dest_port,
                         out_result.source_port, out_result.dest_ip, out_result.source_ip};

endmodule

// ----- design/ethf_checker.sv -----
module ethf_checker import ethf_pkg::*; (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                s_axis_tvalid,
  input logic                s_axis_tready,
  input logic                s_axis_tlast,
  input logic                m_axis_tvalid,
  input logic                m_axis_tready,
  input logic [OutDataW-1:0] m_axis_tdata,
  input logic [VerdictW-1:0] m_axis_tuser
);

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser != VerdictAccept |-> m_axis_tdata[109:96] == '0)
    else $error("payload length on a rejected frame");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("input stalled without a held result");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready && s_axis_tlast, 2))
    else $error("result without a final byte transfer");

endmodule

bind eth_ipv4_udp_header_filter_core ethf_checker u_ethf_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tlast  (s_axis_tlast),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
